### rtl/assert_macros.svh
// Assertion macros for the RTL of the laser proximity stop-and-back block.
// Depends on nothing; the assertion forms are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define LPSB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define LPSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPSB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define LPSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/lpsb_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the stop-and-back block.
// Depends on nothing; every RTL module imports it.
`default_nettype none

package lpsb_pkg;

  localparam int CORDIC_ITERS    = 15;
  localparam int ITERS_PER_STAGE = 3;
  localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;

  // Datapath widths of the CORDIC rotator and of the beam projection.
  localparam int XW = 18;
  localparam int ZW = 17;
  localparam int PW = 33;

  localparam logic signed [XW-1:0] CORDIC_X0 = 18'sd19898;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_DUR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REV_SPEED  = 3'd6;

  typedef enum logic [1:0] {
    KIND_BEAM     = 2'd0,
    KIND_SCAN_END = 2'd1,
    KIND_TICK     = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef struct packed {
    logic [15:0] min_range_mm;
    logic [15:0] max_range_mm;
    logic [15:0] stop_half_width_mm;
    logic [15:0] stop_depth_mm;
    logic [31:0] stop_hold_ms;
    logic [31:0] back_duration_ms;
    logic [14:0] reverse_speed_mm_s;
  } cfg_t;

  // Sideband that travels with each word down the pipeline.
  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [15:0]        range_mm;
    logic [1:0]         quad;
    logic signed [15:0] cmd_linear;
    logic signed [15:0] cmd_angular;
    logic [31:0]        time_ms;
  } item_t;

  function automatic logic signed [ZW-1:0] atan_q(input logic [3:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      4'd0:    v = 17'sd8192;
      4'd1:    v = 17'sd4836;
      4'd2:    v = 17'sd2555;
      4'd3:    v = 17'sd1297;
      4'd4:    v = 17'sd651;
      4'd5:    v = 17'sd326;
      4'd6:    v = 17'sd163;
      4'd7:    v = 17'sd81;
      4'd8:    v = 17'sd41;
      4'd9:    v = 17'sd20;
      4'd10:   v = 17'sd10;
      4'd11:   v = 17'sd5;
      4'd12:   v = 17'sd3;
      4'd13:   v = 17'sd1;
      4'd14:   v = 17'sd1;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/lpsb_cordic_stage.sv
// One registered stage of the sine/cosine CORDIC rotator, ITERS_PER_STAGE iterations deep.
// Depends on lpsb_pkg for widths, the arctangent table and the sideband type.
`default_nettype none

module lpsb_cordic_stage #(
  parameter int FIRST = 0
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           adv,
  input  wire lpsb_pkg::item_t                item_i,
  input  wire logic signed [lpsb_pkg::XW-1:0] x_i,
  input  wire logic signed [lpsb_pkg::XW-1:0] y_i,
  input  wire logic signed [lpsb_pkg::ZW-1:0] z_i,
  output lpsb_pkg::item_t                     item_r,
  output logic signed [lpsb_pkg::XW-1:0]      x_r,
  output logic signed [lpsb_pkg::XW-1:0]      y_r,
  output logic signed [lpsb_pkg::ZW-1:0]      z_r
);
  import lpsb_pkg::*;

  logic signed [XW-1:0] x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;

  // Arithmetic right shifts floor toward minus infinity, as the rotation needs.
  always_comb begin
    logic signed [XW-1:0] dx, dy;
    x_nxt = x_i;
    y_nxt = y_i;
    z_nxt = z_i;
    for (int k = 0; k < ITERS_PER_STAGE; k++) begin
      dx = y_nxt >>> (FIRST + k);
      dy = x_nxt >>> (FIRST + k);
      if (!z_nxt[ZW-1]) begin
        x_nxt = x_nxt - dx;
        y_nxt = y_nxt + dy;
        z_nxt = z_nxt - atan_q(4'(FIRST + k));
      end else begin
        x_nxt = x_nxt + dx;
        y_nxt = y_nxt - dy;
        z_nxt = z_nxt + atan_q(4'(FIRST + k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (adv) begin
      item_r <= item_i;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/lpsb_beam_proj.sv
// Saturates the CORDIC outputs, unfolds the quadrant and projects the beam onto x and y.
// Depends on lpsb_pkg; one multiplier per axis, registered.
`default_nettype none

module lpsb_beam_proj (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           adv,
  input  wire lpsb_pkg::item_t                item_i,
  input  wire logic signed [lpsb_pkg::XW-1:0] x_i,
  input  wire logic signed [lpsb_pkg::XW-1:0] y_i,
  output lpsb_pkg::item_t                     item_r,
  output logic signed [lpsb_pkg::PW-1:0]      px_r,
  output logic signed [lpsb_pkg::PW-1:0]      py_r
);
  import lpsb_pkg::*;

  localparam logic signed [XW-1:0] SAT_HI = 18'sd32767;
  localparam logic signed [XW-1:0] SAT_LO = -18'sd32767;

  logic signed [15:0] xs, ys, sin_v, cos_v;
  logic signed [16:0] r_s;
  logic signed [PW-1:0] px_nxt, py_nxt;

  function automatic logic signed [15:0] sat15(input logic signed [XW-1:0] v);
    logic signed [15:0] o;
    if (v > SAT_HI)      o = 16'sd32767;
    else if (v < SAT_LO) o = -16'sd32767;
    else                 o = v[15:0];
    return o;
  endfunction

  always_comb begin
    xs = sat15(x_i);
    ys = sat15(y_i);
    unique case (item_i.quad)
      2'd0: begin sin_v = ys;  cos_v = xs;  end
      2'd1: begin sin_v = xs;  cos_v = -ys; end
      2'd2: begin sin_v = -ys; cos_v = -xs; end
      2'd3: begin sin_v = -xs; cos_v = ys;  end
      default: begin sin_v = ys; cos_v = xs; end
    endcase
    r_s    = $signed({1'b0, item_i.range_mm});
    px_nxt = r_s * sin_v;
    py_nxt = r_s * cos_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (adv) begin
      item_r <= item_i;
      px_r   <= px_nxt;
      py_r   <= py_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/lpsb_supervisor.sv
// Box test, hit counter, scan latch, stop/reverse timing and the result register.
// Depends on lpsb_pkg for the configuration and sideband types.
`default_nettype none

module lpsb_supervisor #(
  parameter int STOP_COUNT = 5
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           adv,
  input  wire lpsb_pkg::cfg_t                 cfg,
  input  wire lpsb_pkg::item_t                item_i,
  input  wire logic signed [lpsb_pkg::PW-1:0] px_i,
  input  wire logic signed [lpsb_pkg::PW-1:0] py_i,
  output logic                                out_valid_r,
  output logic signed [15:0]                  out_linear_r,
  output logic signed [15:0]                  out_angular_r,
  output logic                                out_stop_seen_r,
  output logic                                out_reversing_r
);
  import lpsb_pkg::*;

  localparam int HW = $clog2(STOP_COUNT + 1);
  localparam logic [HW-1:0] HIT_LIMIT = HW'(STOP_COUNT);

  logic [HW-1:0] box_hits_r, box_hits_nxt;
  logic          obst_r, obst_nxt;
  logic          await_r, await_nxt;
  logic          backing_r, backing_nxt;
  logic [31:0]   stop_start_r, stop_start_nxt;
  logic [31:0]   back_start_r, back_start_nxt;
  logic signed [15:0] lin_nxt, ang_nxt;

  logic signed [PW-1:0] hw_lim, depth_lim;
  logic in_range, in_box;

  always_comb begin
    hw_lim    = $signed({2'b00, cfg.stop_half_width_mm, 15'd0});
    depth_lim = $signed({2'b00, cfg.stop_depth_mm, 15'd0});
    in_range  = (item_i.range_mm >= cfg.min_range_mm) &&
                (item_i.range_mm <= cfg.max_range_mm);
    in_box    = (px_i < hw_lim) && (px_i > -hw_lim) && (py_i < depth_lim);
  end

  always_comb begin
    logic [31:0] stop_el, back_el;
    box_hits_nxt   = box_hits_r;
    obst_nxt       = obst_r;
    await_nxt      = await_r;
    backing_nxt    = backing_r;
    stop_start_nxt = stop_start_r;
    back_start_nxt = back_start_r;
    lin_nxt        = item_i.cmd_linear;
    ang_nxt        = item_i.cmd_angular;
    stop_el        = item_i.time_ms - stop_start_r;
    back_el        = 32'd0;
    if (item_i.valid) begin
      unique case (item_i.kind)
        KIND_BEAM: begin
          if (in_range && in_box && (box_hits_r < HIT_LIMIT)) begin
            box_hits_nxt = box_hits_r + HW'(1);
          end
        end
        KIND_SCAN_END: begin
          obst_nxt     = (box_hits_r >= HIT_LIMIT);
          box_hits_nxt = '0;
        end
        KIND_TICK: begin
          if ((cfg.stop_half_width_mm != 16'd0) && obst_r) begin
            lin_nxt = 16'sd0;
            ang_nxt = 16'sd0;
            if (await_r) begin
              stop_start_nxt = item_i.time_ms;
              await_nxt      = 1'b0;
            end else if ((stop_el > cfg.stop_hold_ms) && !backing_r) begin
              back_start_nxt = item_i.time_ms;
              backing_nxt    = 1'b1;
            end
          end else begin
            await_nxt = 1'b1;
          end
          back_el = item_i.time_ms - back_start_nxt;
          if (backing_nxt) begin
            lin_nxt = -$signed({1'b0, cfg.reverse_speed_mm_s});
            ang_nxt = 16'sd0;
            if (back_el > cfg.back_duration_ms) begin
              lin_nxt     = 16'sd0;
              backing_nxt = 1'b0;
            end
          end
        end
        KIND_NONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_hits_r   <= '0;
      obst_r       <= 1'b0;
      await_r      <= 1'b1;
      backing_r    <= 1'b0;
      stop_start_r <= 32'd0;
      back_start_r <= 32'd0;
      out_valid_r  <= 1'b0;
    end else if (adv) begin
      box_hits_r   <= box_hits_nxt;
      obst_r       <= obst_nxt;
      await_r      <= await_nxt;
      backing_r    <= backing_nxt;
      stop_start_r <= stop_start_nxt;
      back_start_r <= back_start_nxt;
      out_valid_r  <= item_i.valid && (item_i.kind == KIND_TICK);
      out_linear_r    <= lin_nxt;
      out_angular_r   <= ang_nxt;
      out_stop_seen_r <= obst_r;
      out_reversing_r <= backing_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/laser_proximity_stop_and_back.sv
// Top level of the laser proximity stop-and-back supervisor: ports, configuration
// registers and the pipeline. Depends on lpsb_pkg, assert_macros.svh and the lpsb_ modules.
//
//  Channel  Direction  Handshake               Payload
//  in_      input      in_valid / in_ready     kind, range_mm, beam_angle, cmd_*, time_ms
//  out_     output     out_valid / out_ready   out_linear, out_angular, stop_seen, reversing
//  cfg_     input      cfg_wr_en (no wait)     cfg_index, cfg_wdata
//
// One word is accepted every cycle unless a result word waits with out_ready low; a word's
// effect reaches the result register through seven registers: five CORDIC stages of three
// iterations each, one multiply stage and the decision stage. Reset is synchronous and
// active low; it clears the pipeline, the supervision state and loads the configuration
// defaults. While a result word waits in the output register and out_ready is low, the
// whole pipeline holds and in_ready is low.
`default_nettype none
`include "assert_macros.svh"

module laser_proximity_stop_and_back #(
  parameter int STOP_COUNT = 5,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_kind,
  input  wire logic [15:0]                       in_range_mm,
  input  wire logic [15:0]                       in_beam_angle,
  input  wire logic signed [15:0]                in_cmd_linear,
  input  wire logic signed [15:0]                in_cmd_angular,
  input  wire logic [31:0]                       in_time_ms,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [15:0]                     out_linear,
  output logic signed [15:0]                     out_angular,
  output logic                                   out_stop_seen,
  output logic                                   out_reversing,
  input  wire logic                              cfg_wr_en,
  input  wire logic [lpsb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [31:0]                       cfg_wdata
);
  import lpsb_pkg::*;

  // The angle keeps only its top ANGLE_BITS bits before the rotation.
  localparam int unsigned ANGLE_DROP = 16 - ANGLE_BITS;
  localparam logic [15:0] ANGLE_MASK = 16'(32'hFFFF << ANGLE_DROP);

  cfg_t cfg_r;

  // The pipeline moves only when the result register is free or being emptied.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_range_mm       <= 16'd0;
      cfg_r.max_range_mm       <= 16'd65535;
      cfg_r.stop_half_width_mm <= 16'd600;
      cfg_r.stop_depth_mm      <= 16'd400;
      cfg_r.stop_hold_ms       <= 32'd3000;
      cfg_r.back_duration_ms   <= 32'd5000;
      cfg_r.reverse_speed_mm_s <= 15'd200;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MIN_RANGE:  cfg_r.min_range_mm       <= cfg_wdata[15:0];
        REG_MAX_RANGE:  cfg_r.max_range_mm       <= cfg_wdata[15:0];
        REG_HALF_WIDTH: cfg_r.stop_half_width_mm <= cfg_wdata[15:0];
        REG_DEPTH:      cfg_r.stop_depth_mm      <= cfg_wdata[15:0];
        REG_HOLD:       cfg_r.stop_hold_ms       <= cfg_wdata;
        REG_BACK_DUR:   cfg_r.back_duration_ms   <= cfg_wdata;
        REG_REV_SPEED:  cfg_r.reverse_speed_mm_s <= cfg_wdata[14:0];
        default: begin
        end
      endcase
    end
  end

  // Every kind of word enters the same pipeline, so the counter, the scan latch and
  // the timers see beams, scan ends and ticks in the order they arrived.
  item_t                stg_item [0:CORDIC_STAGES];
  logic signed [XW-1:0] stg_x    [0:CORDIC_STAGES];
  logic signed [XW-1:0] stg_y    [0:CORDIC_STAGES];
  logic signed [ZW-1:0] stg_z    [0:CORDIC_STAGES];
  logic [15:0]          angle_m;

  always_comb begin
    angle_m                 = in_beam_angle & ANGLE_MASK;
    stg_item[0].valid       = in_valid;
    stg_item[0].kind        = kind_t'(in_kind);
    stg_item[0].range_mm    = in_range_mm;
    stg_item[0].quad        = angle_m[15:14];
    stg_item[0].cmd_linear  = in_cmd_linear;
    stg_item[0].cmd_angular = in_cmd_angular;
    stg_item[0].time_ms     = in_time_ms;
    stg_x[0]                = CORDIC_X0;
    stg_y[0]                = '0;
    stg_z[0]                = $signed({3'b000, angle_m[13:0]});
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    lpsb_cordic_stage #(
      .FIRST (g * ITERS_PER_STAGE)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .item_i (stg_item[g]),
      .x_i    (stg_x[g]),
      .y_i    (stg_y[g]),
      .z_i    (stg_z[g]),
      .item_r (stg_item[g+1]),
      .x_r    (stg_x[g+1]),
      .y_r    (stg_y[g+1]),
      .z_r    (stg_z[g+1])
    );
  end

  item_t                proj_item;
  logic signed [PW-1:0] proj_px, proj_py;

  lpsb_beam_proj u_proj (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item_i (stg_item[CORDIC_STAGES]),
    .x_i    (stg_x[CORDIC_STAGES]),
    .y_i    (stg_y[CORDIC_STAGES]),
    .item_r (proj_item),
    .px_r   (proj_px),
    .py_r   (proj_py)
  );

  lpsb_supervisor #(
    .STOP_COUNT (STOP_COUNT)
  ) u_sup (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .cfg             (cfg_r),
    .item_i          (proj_item),
    .px_i            (proj_px),
    .py_i            (proj_py),
    .out_valid_r     (out_valid),
    .out_linear_r    (out_linear),
    .out_angular_r   (out_angular),
    .out_stop_seen_r (out_stop_seen),
    .out_reversing_r (out_reversing)
  );

  // While reversing, the command is exactly the configured reverse speed with no turn.
  `LPSB_ASSERT_NOW(a_rev_speed, clk, rst_n, out_valid && out_reversing, out_linear == -$signed({1'b0, cfg_r.reverse_speed_mm_s}), "reverse speed mismatch")
  `LPSB_ASSERT_NOW(a_rev_no_turn, clk, rst_n, out_valid && out_reversing, out_angular == 16'sd0, "turning while reversing")
  // An enabled, latched stop that is not reversing must give a zero command.
  `LPSB_ASSERT_NOW(a_stop_zero, clk, rst_n, out_valid && out_stop_seen && !out_reversing && (cfg_r.stop_half_width_mm != 16'd0), (out_linear == 16'sd0) && (out_angular == 16'sd0), "command passed while stopped")
  // A waiting result word blocks the input and stays put until it is taken.
  `LPSB_ASSERT_NOW(a_stall_hold, clk, rst_n, out_valid && !out_ready, !in_ready, "accepted while stalled")
  `LPSB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_linear) && $stable(out_angular), "result changed while waiting")

endmodule

`default_nettype wire
